>>> hw/rtl/trqs_pkg.sv
// shared types, codes and defaults for the thread ready-queue scheduler
`default_nettype none

package trqs_pkg;

  // default thread table size
  localparam int MAX_THREADS_DEF = 16;

  // operation codes
  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_YIELD  = 2'd1,
    OP_SCHED  = 2'd2,
    OP_EXIT   = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_FULL       = 3'd1,
    ST_BAD_ID     = 3'd2,
    ST_NO_THREAD  = 3'd3,
    ST_ALL_EXITED = 3'd4
  } status_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SEARCH,
    S_UL_RD,
    S_UL_WR,
    S_AT_RD,
    S_AT_WR1,
    S_AT_WR2,
    S_PH_RD,
    S_PH_WR1,
    S_PH_WR2,
    S_HD_RD,
    S_HD_ID,
    S_CTX_RD,
    S_DISP,
    S_DONE
  } state_t;

  // input beat
  typedef struct packed {
    logic [1:0]         op;
    logic [3:0]         target_thread;
    logic [31:0]        entry_addr;
    logic signed [31:0] argument;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic [2:0]         status;
    logic [3:0]         thread_id;
    logic [3:0]         current_thread;
    logic [3:0]         previous_thread;
    logic               switched;
    logic               first_run;
    logic [31:0]        start_entry;
    logic signed [31:0] start_argument;
  } out_item_t;

  // link table port controls
  typedef struct packed {
    logic rd_en;
    logic nx_we;
    logic pv_we;
  } link_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/trqs_link_ram.sv
// next/prev link tables of the ready ring, with per-node reset overlay
`default_nettype none

module trqs_link_ram import trqs_pkg::*; #(
  parameter int  MAX_THREADS = MAX_THREADS_DEF,
  localparam int NODES       = MAX_THREADS + 1,
  localparam int NW          = $clog2(MAX_THREADS + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire link_ctl_t     ctl,
  input  wire logic [NW-1:0] rd_addr,
  input  wire logic [NW-1:0] nx_addr,
  input  wire logic [NW-1:0] nx_data,
  input  wire logic [NW-1:0] pv_addr,
  input  wire logic [NW-1:0] pv_data,
  output logic      [NW-1:0] rd_next,
  output logic      [NW-1:0] rd_prev
);

  logic [NW-1:0]    next_mem [NODES];
  logic [NW-1:0]    prev_mem [NODES];
  logic [NODES-1:0] nx_vld_r;
  logic [NODES-1:0] pv_vld_r;
  logic [NW-1:0]    nx_q_r;
  logic [NW-1:0]    pv_q_r;
  logic [NW-1:0]    rd_addr_r;
  logic             nx_hit_r;
  logic             pv_hit_r;
  logic [NW-1:0]    rst_val;

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (ctl.nx_we) begin
      next_mem[nx_addr] <= nx_data;
    end
    if (ctl.pv_we) begin
      prev_mem[pv_addr] <= pv_data;
    end
    if (ctl.rd_en) begin
      nx_q_r    <= next_mem[rd_addr];
      pv_q_r    <= prev_mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  // written-since-reset flags per node
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nx_vld_r <= '0;
      pv_vld_r <= '0;
      nx_hit_r <= 1'b0;
      pv_hit_r <= 1'b0;
    end else begin
      if (ctl.nx_we) begin
        nx_vld_r[nx_addr] <= 1'b1;
      end
      if (ctl.pv_we) begin
        pv_vld_r[pv_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        nx_hit_r <= nx_vld_r[rd_addr];
        pv_hit_r <= pv_vld_r[rd_addr];
      end
    end
  end

  // after reset the ring is sentinel <-> thread 0
  assign rst_val = (rd_addr_r == '0) ? NW'(1) : '0;
  assign rd_next = nx_hit_r ? nx_q_r : rst_val;
  assign rd_prev = pv_hit_r ? pv_q_r : rst_val;

endmodule

`default_nettype wire

>>> hw/rtl/trqs_ctx_ram.sv
// entry address and argument store per thread slot
`default_nettype none

module trqs_ctx_ram import trqs_pkg::*; #(
  parameter int  MAX_THREADS = MAX_THREADS_DEF,
  localparam int IDW         = $clog2(MAX_THREADS)
) (
  input  wire logic               clk,
  input  wire logic               we,
  input  wire logic [IDW-1:0]     waddr,
  input  wire logic [31:0]        wentry,
  input  wire logic signed [31:0] warg,
  input  wire logic [IDW-1:0]     raddr,
  output logic      [31:0]        rentry,
  output logic signed [31:0]      rarg
);

  logic [31:0]        entry_mem [MAX_THREADS];
  logic signed [31:0] arg_mem   [MAX_THREADS];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      entry_mem[waddr] <= wentry;
      arg_mem[waddr]   <= warg;
    end
    rentry <= entry_mem[raddr];
    rarg   <= arg_mem[raddr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/thread_ready_queue_scheduler.sv
// top level: sequencer over the link and context tables of the thread scheduler
//
//  channel | direction | handshake          | beat
//  --------+-----------+--------------------+-----------
//  in_     | input     | in_valid/in_stall  | in_item_t
//  out_    | output    | out_valid/out_stall| out_item_t
//
// one beat at a time: in_stall is high from acceptance until the result is loaded
// into the output register; the link table has one read and one write per cycle
// and sets the length of each operation; a create probes the slots in turn,
// up to MAX_THREADS of them
// reset is synchronous and leaves the ring holding thread 0 only; a stalled
// result holds in the output register while the next beat is already taken
`default_nettype none

module thread_ready_queue_scheduler import trqs_pkg::*; #(
  parameter int MAX_THREADS = MAX_THREADS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item
);

  localparam int IDW = $clog2(MAX_THREADS);
  localparam int NW  = $clog2(MAX_THREADS + 1);
  localparam int LW  = $clog2(MAX_THREADS + 1);

  state_t           state_r, state_nxt;
  in_item_t         item_r;
  out_item_t        res_r;
  out_item_t        dec_res;
  out_item_t        out_item_r;
  logic             out_valid_r;
  logic [MAX_THREADS-1:0] slot_valid_r;
  logic [MAX_THREADS-1:0] not_started_r;
  logic [IDW-1:0]   running_r;
  logic [IDW-1:0]   last_alloc_r;
  logic [IDW-1:0]   cand_r;
  logic [IDW-1:0]   disp_id_r;
  logic [LW-1:0]    live_r;
  logic [LW-1:0]    search_cnt_r;
  logic [NW-1:0]    node_r;
  logic             yield_tail_r;

  op_t              op_w;
  logic [IDW-1:0]   tgt_id;
  logic             tgt_in_range;
  logic             tgt_live;
  logic [NW-1:0]    cur_node;
  logic [NW-1:0]    tgt_node;
  logic [IDW-1:0]   cand_inc;
  logic [IDW-1:0]   last_inc;
  logic [IDW-1:0]   head_id;
  logic             slot_free;
  logic             out_free;

  link_ctl_t        lk_ctl;
  logic [NW-1:0]    lk_rd_addr, lk_nx_addr, lk_nx_data, lk_pv_addr, lk_pv_data;
  logic [NW-1:0]    lk_rd_next, lk_rd_prev;
  logic             ctx_we;
  logic [31:0]      ctx_entry;
  logic signed [31:0] ctx_arg;

  // link tables
  trqs_link_ram #(.MAX_THREADS(MAX_THREADS)) u_link (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (lk_ctl),
    .rd_addr (lk_rd_addr),
    .nx_addr (lk_nx_addr),
    .nx_data (lk_nx_data),
    .pv_addr (lk_pv_addr),
    .pv_data (lk_pv_data),
    .rd_next (lk_rd_next),
    .rd_prev (lk_rd_prev)
  );

  // entry and argument store
  trqs_ctx_ram #(.MAX_THREADS(MAX_THREADS)) u_ctx (
    .clk    (clk),
    .we     (ctx_we),
    .waddr  (cand_r),
    .wentry (item_r.entry_addr),
    .warg   (item_r.argument),
    .raddr  (disp_id_r),
    .rentry (ctx_entry),
    .rarg   (ctx_arg)
  );

  // decode helpers and the increment/compare logic
  assign op_w         = op_t'(item_r.op);
  assign tgt_id       = IDW'(item_r.target_thread);
  assign tgt_in_range = 32'(item_r.target_thread) < 32'(MAX_THREADS);
  assign tgt_live     = tgt_in_range ? slot_valid_r[tgt_id] : 1'b0;
  assign cur_node     = NW'(running_r) + NW'(1);
  assign tgt_node     = NW'(tgt_id) + NW'(1);
  assign cand_inc     = (cand_r == IDW'(MAX_THREADS - 1)) ? '0 : cand_r + IDW'(1);
  assign last_inc     = (last_alloc_r == IDW'(MAX_THREADS - 1)) ? '0 :
                        last_alloc_r + IDW'(1);
  assign head_id      = (lk_rd_next == '0) ? running_r : IDW'(lk_rd_next - NW'(1));
  assign slot_free    = !slot_valid_r[cand_r];
  assign out_free     = !out_valid_r || !out_stall;

  // result fields known at decode
  always_comb begin
    dec_res                 = '0;
    dec_res.status          = ST_OK;
    dec_res.current_thread  = 4'(running_r);
    dec_res.previous_thread = 4'(running_r);
    if (live_r == '0) begin
      dec_res.status = ST_ALL_EXITED;
    end else begin
      case (op_w)
        OP_CREATE: begin
          if (live_r >= LW'(MAX_THREADS)) dec_res.status = ST_FULL;
        end
        OP_YIELD: begin
          dec_res.thread_id = item_r.target_thread;
          if (!tgt_in_range) begin
            dec_res.status = ST_BAD_ID;
          end else if (!tgt_live) begin
            dec_res.status = ST_NO_THREAD;
          end
        end
        OP_EXIT: begin
          if (live_r <= LW'(1)) dec_res.status = ST_ALL_EXITED;
        end
        default: begin
        end
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        if (live_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          case (op_w)
            OP_CREATE: begin
              state_nxt = (live_r >= LW'(MAX_THREADS)) ? S_DONE : S_SEARCH;
            end
            OP_YIELD: begin
              state_nxt = (!tgt_live || tgt_id == running_r) ? S_DONE : S_UL_RD;
            end
            OP_EXIT: begin
              state_nxt = (live_r <= LW'(1)) ? S_DONE : S_UL_RD;
            end
            default: begin
              state_nxt = S_UL_RD;
            end
          endcase
        end
      end
      S_SEARCH: begin
        if (slot_free) begin
          state_nxt = S_AT_RD;
        end else if (search_cnt_r == LW'(MAX_THREADS - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_UL_RD: state_nxt = S_UL_WR;
      S_UL_WR: begin
        if (op_w == OP_EXIT) begin
          state_nxt = S_HD_RD;
        end else if (yield_tail_r) begin
          state_nxt = S_PH_RD;
        end else begin
          state_nxt = S_AT_RD;
        end
      end
      S_AT_RD:  state_nxt = S_AT_WR1;
      S_AT_WR1: state_nxt = S_AT_WR2;
      S_AT_WR2: begin
        case (op_w)
          OP_SCHED: state_nxt = S_HD_RD;
          OP_YIELD: state_nxt = S_UL_RD;
          default:  state_nxt = S_DONE;
        endcase
      end
      S_PH_RD:  state_nxt = S_PH_WR1;
      S_PH_WR1: state_nxt = S_PH_WR2;
      S_PH_WR2: state_nxt = S_CTX_RD;
      S_HD_RD:  state_nxt = S_HD_ID;
      S_HD_ID:  state_nxt = S_CTX_RD;
      S_CTX_RD: state_nxt = S_DISP;
      S_DISP:   state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // table port controls per state
  always_comb begin
    lk_ctl     = '0;
    lk_rd_addr = '0;
    lk_nx_addr = '0;
    lk_nx_data = '0;
    lk_pv_addr = '0;
    lk_pv_data = '0;
    ctx_we     = 1'b0;
    case (state_r)
      S_SEARCH: begin
        ctx_we = slot_free;
      end
      // unlink: next[prev] = next, prev[next] = prev
      S_UL_RD: begin
        lk_ctl.rd_en = 1'b1;
        lk_rd_addr   = node_r;
      end
      S_UL_WR: begin
        lk_ctl.nx_we = 1'b1;
        lk_nx_addr   = lk_rd_prev;
        lk_nx_data   = lk_rd_next;
        lk_ctl.pv_we = 1'b1;
        lk_pv_addr   = lk_rd_next;
        lk_pv_data   = lk_rd_prev;
      end
      // read the sentinel links; append at tail, behind the sentinel
      S_AT_RD, S_PH_RD, S_HD_RD: begin
        lk_ctl.rd_en = 1'b1;
        lk_rd_addr   = '0;
      end
      S_AT_WR1: begin
        lk_ctl.nx_we = 1'b1;
        lk_nx_addr   = lk_rd_prev;
        lk_nx_data   = node_r;
        lk_ctl.pv_we = 1'b1;
        lk_pv_addr   = node_r;
        lk_pv_data   = lk_rd_prev;
      end
      S_AT_WR2: begin
        lk_ctl.pv_we = 1'b1;
        lk_pv_addr   = '0;
        lk_pv_data   = node_r;
        lk_ctl.nx_we = 1'b1;
        lk_nx_addr   = node_r;
        lk_nx_data   = '0;
      end
      // push at head, after the sentinel
      S_PH_WR1: begin
        lk_ctl.nx_we = 1'b1;
        lk_nx_addr   = node_r;
        lk_nx_data   = lk_rd_next;
        lk_ctl.pv_we = 1'b1;
        lk_pv_addr   = node_r;
        lk_pv_data   = '0;
      end
      S_PH_WR2: begin
        lk_ctl.pv_we = 1'b1;
        lk_pv_addr   = lk_rd_next;
        lk_pv_data   = node_r;
        lk_ctl.nx_we = 1'b1;
        lk_nx_addr   = '0;
        lk_nx_data   = node_r;
      end
      default: begin
      end
    endcase
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // scheduler control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      slot_valid_r  <= MAX_THREADS'(1);
      not_started_r <= '0;
      running_r     <= '0;
      last_alloc_r  <= '0;
      live_r        <= LW'(1);
      yield_tail_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_DECODE: begin
          yield_tail_r <= 1'b0;
          if (live_r != '0 && op_w == OP_EXIT) begin
            if (live_r <= LW'(1)) begin
              live_r <= '0;
            end else begin
              live_r                  <= live_r - LW'(1);
              slot_valid_r[running_r] <= 1'b0;
            end
          end
        end
        S_SEARCH: begin
          if (slot_free) begin
            slot_valid_r[cand_r]  <= 1'b1;
            not_started_r[cand_r] <= 1'b1;
            last_alloc_r          <= cand_r;
            live_r                <= live_r + LW'(1);
          end
        end
        S_AT_WR2: begin
          if (op_w == OP_YIELD) yield_tail_r <= 1'b1;
        end
        S_DISP: begin
          not_started_r[disp_id_r] <= 1'b0;
          running_r                <= disp_id_r;
        end
        S_DONE: begin
          if (out_free) out_valid_r <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // beat and work registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_valid) item_r <= in_item;
      end
      S_DECODE: begin
        res_r        <= dec_res;
        node_r       <= cur_node;
        cand_r       <= last_inc;
        search_cnt_r <= '0;
      end
      S_SEARCH: begin
        if (slot_free) begin
          node_r          <= NW'(cand_r) + NW'(1);
          res_r.thread_id <= 4'(cand_r);
        end else begin
          cand_r       <= cand_inc;
          search_cnt_r <= search_cnt_r + LW'(1);
          if (search_cnt_r == LW'(MAX_THREADS - 1)) res_r.status <= ST_FULL;
        end
      end
      S_AT_WR2: begin
        if (op_w == OP_YIELD) node_r <= tgt_node;
      end
      S_PH_WR2: begin
        disp_id_r <= tgt_id;
      end
      S_HD_ID: begin
        disp_id_r <= head_id;
      end
      // dispatch: set the current thread and switch flag; first run hands out the stored context
      S_DISP: begin
        res_r.current_thread <= 4'(disp_id_r);
        res_r.switched       <= (disp_id_r != running_r);
        if (not_started_r[disp_id_r]) begin
          res_r.first_run      <= 1'b1;
          res_r.start_entry    <= ctx_entry;
          res_r.start_argument <= ctx_arg;
        end
      end
      S_DONE: begin
        if (out_free) out_item_r <= res_r;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/trqs_checker.sv
// port-level checks on the thread scheduler, bound to the top level
`default_nettype none

module trqs_checker import trqs_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_item
);

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
    else $error("result changed while stalled");

  // one beat in flight: busy right after acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a beat is in flight");

  // a result only appears at the end of a busy stretch
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without work");

  // error and all-exited results leave the running thread alone
  a_error_no_switch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status != ST_OK) |->
      (!out_item.switched && !out_item.first_run &&
       out_item.current_thread == out_item.previous_thread))
    else $error("thread switch on an error result");

  // a fresh thread is never the one that was already running
  a_first_run_switches: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.first_run) |-> out_item.switched)
    else $error("first run without a switch");

endmodule

bind thread_ready_queue_scheduler trqs_checker u_trqs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

`default_nettype wire
